@@ rtl/kvrt_pkg.sv @@
// Shared types and constants for the keyed value range table.
package kvrt_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 64;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_NEW       = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_READ_MISS = 3'd4
  } status_e;

  typedef enum logic {
    MODE_RECORD = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [15:0]        ctl_page;
    logic [15:0]        usage;
    logic signed [31:0] observed;
    logic signed [31:0] declared_min;
    logic signed [31:0] declared_max;
    logic [5:0]         read_index;
  } kvrt_in_t;

  typedef struct packed {
    status_e            status;
    logic [5:0]         entry_index;
    logic [6:0]         entries_used;
    logic [15:0]        entry_page;
    logic [15:0]        entry_usage;
    logic signed [31:0] entry_declared_min;
    logic signed [31:0] entry_declared_max;
    logic signed [31:0] seen_min;
    logic signed [31:0] seen_max;
    logic [31:0]        hit_count;
    logic [31:0]        all_events;
  } kvrt_out_t;

  // One table entry as it travels along the chain.
  typedef struct packed {
    logic [15:0]        page;
    logic [15:0]        usage;
    logic signed [31:0] decl_min;
    logic signed [31:0] decl_max;
    logic signed [31:0] seen_min;
    logic signed [31:0] seen_max;
    logic [31:0]        count;
  } kvrt_entry_t;

  // What happened to the entry passing the head in this cycle.
  typedef struct packed {
    logic matched;
    logic created;
    logic read;
  } kvrt_evt_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

@@ rtl/kvrt_cell.sv @@
// One storage cell of the rotating entry chain.
module kvrt_cell
  import kvrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        shift_i,
  input  kvrt_entry_t entry_i,
  output kvrt_entry_t entry_o
);

  kvrt_entry_t entry_q;

  // Entry contents are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/kvrt_head.sv @@
// Compare and update logic applied to the entry leaving the head of the chain.
module kvrt_head
  import kvrt_pkg::*;
#(
  parameter int IW = 7
) (
  input  kvrt_in_t        query_i,
  input  logic            hit_i,
  input  logic [IW-1:0]   pos_i,
  input  logic [IW-1:0]   fill_i,
  input  kvrt_entry_t     entry_i,
  output kvrt_entry_t     entry_o,
  output kvrt_evt_t       evt_o
);

  logic        filled;
  logic        is_record;
  kvrt_entry_t upd;
  kvrt_entry_t fresh;

  assign filled    = pos_i < fill_i;
  assign is_record = (query_i.mode == MODE_RECORD);

  always_comb begin
    evt_o.matched = is_record && filled && !hit_i &&
                    (entry_i.page == query_i.ctl_page) &&
                    (entry_i.usage == query_i.usage);
    // The first slot past the fill level is reached only after every filled slot.
    evt_o.created = is_record && !hit_i && (pos_i == fill_i);
    evt_o.read    = !is_record && filled && (32'(query_i.read_index) == 32'(pos_i));

    upd = entry_i;
    if (query_i.observed < entry_i.seen_min) begin
      upd.seen_min = query_i.observed;
    end
    if (query_i.observed > entry_i.seen_max) begin
      upd.seen_max = query_i.observed;
    end
    upd.count = sat_inc(entry_i.count);

    fresh.page     = query_i.ctl_page;
    fresh.usage    = query_i.usage;
    fresh.decl_min = query_i.declared_min;
    fresh.decl_max = query_i.declared_max;
    fresh.seen_min = query_i.observed;
    fresh.seen_max = query_i.observed;
    fresh.count    = 32'd1;

    priority if (evt_o.matched) begin
      entry_o = upd;
    end else if (evt_o.created) begin
      entry_o = fresh;
    end else begin
      entry_o = entry_i;
    end
  end

endmodule

@@ rtl/keyed_value_range_table_top.sv @@
// Top level of the keyed value range table: control, chain of entry cells and result register.
//
// The table lives in a ring of TABLE_ENTRIES cells that rotates by one cell per clock while
// an item is worked on; a single compare and update unit sits at the head of the ring and
// sees every entry once per full turn. An item is accepted when start_i is high and busy_o
// is low. Every item, record or read, takes exactly one full turn of the ring, after which
// the ring is back in its home position and the result is presented on res_o with
// res_valid_o high for exactly one cycle; the result is taken at the edge that ends that
// strobe cycle. The result sits in its own register, so busy_o is already low during that
// strobe cycle and the next transfer can be accepted there. The receiver cannot stall the
// block and must take each result in the cycle it is shown. Table entries are not cleared
// by reset; only entries below the fill level, or one just created at it, are ever
// reported, so no clearing pass is needed.
module keyed_value_range_table_top
  import kvrt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  kvrt_in_t  req_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output kvrt_out_t res_o
);

  // Position and fill counters must hold the entry count itself.
  localparam int IW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LastPos = IW'(TABLE_ENTRIES - 1);

  state_e        state_q, state_d;
  logic [IW-1:0] pos_q;
  logic [IW-1:0] fill_q, fill_d;
  logic [31:0]   total_q;
  logic          hit_q;
  logic          res_valid_q;
  kvrt_in_t      query_q;
  kvrt_out_t     res_q;

  logic          accept;
  logic          shift;
  logic          last;

  kvrt_entry_t   cell_out [TABLE_ENTRIES];
  kvrt_entry_t   head_out;
  kvrt_evt_t     evt;

  assign accept = start_i && (state_q == S_IDLE);
  assign shift  = (state_q == S_RUN);
  assign last   = shift && (pos_q == LastPos);

  // Next-state logic of the controller.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (pos_q == LastPos) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The ring: cell k takes the contents of cell k+1, and the last cell takes the entry
  // coming out of the head unit, possibly updated or newly created.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    kvrt_entry_t cell_in;
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign cell_in = head_out;
    end else begin : g_mid
      assign cell_in = cell_out[k+1];
    end
    kvrt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (cell_out[k])
    );
  end

  kvrt_head #(
    .IW (IW)
  ) u_head (
    .query_i (query_q),
    .hit_i   (hit_q),
    .pos_i   (pos_q),
    .fill_i  (fill_q),
    .entry_i (cell_out[0]),
    .entry_o (head_out),
    .evt_o   (evt)
  );

  assign fill_d = (shift && evt.created) ? fill_q + IW'(1) : fill_q;

  // Control counters. The event total already counts a record item from its acceptance on,
  // which is the value the result reports. Once a record item has found or created its
  // entry, the rest of the turn leaves the table alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= last;
      fill_q      <= fill_d;
      if (accept) begin
        pos_q <= '0;
        hit_q <= 1'b0;
        if (req_i.mode == MODE_RECORD) begin
          total_q <= sat_inc(total_q);
        end
      end else if (shift) begin
        pos_q <= pos_q + IW'(1);
        if (evt.matched || evt.created) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Query and result payload. The result starts out as the no-entry outcome and is
  // overwritten when the head unit finds, creates or reads an entry.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q                  <= req_i;
      res_q.status             <= (req_i.mode == MODE_READ) ? ST_READ_MISS : ST_DROPPED;
      res_q.entry_index        <= '0;
      res_q.entry_page         <= '0;
      res_q.entry_usage        <= '0;
      res_q.entry_declared_min <= '0;
      res_q.entry_declared_max <= '0;
      res_q.seen_min           <= '0;
      res_q.seen_max           <= '0;
      res_q.hit_count          <= '0;
    end else if (shift) begin
      if (evt.matched || evt.created || evt.read) begin
        priority if (evt.matched) begin
          res_q.status <= ST_UPDATED;
        end else if (evt.created) begin
          res_q.status <= ST_NEW;
        end else begin
          res_q.status <= ST_READ_OK;
        end
        res_q.entry_index        <= 6'(pos_q);
        res_q.entry_page         <= head_out.page;
        res_q.entry_usage        <= head_out.usage;
        res_q.entry_declared_min <= head_out.decl_min;
        res_q.entry_declared_max <= head_out.decl_max;
        res_q.seen_min           <= head_out.seen_min;
        res_q.seen_max           <= head_out.seen_max;
        res_q.hit_count          <= head_out.count;
      end
      if (last) begin
        res_q.entries_used <= 7'(fill_d);
        res_q.all_events   <= total_q;
      end
    end
  end

  assign busy_o      = shift;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
